/* hdl/pqga_pkg.sv */
// Shared widths, codes, pipeline types and helper functions for the previous QG address block.
package pqga_pkg;

  localparam int unsigned COORD_W    = 13;
  localparam int unsigned ENTRY_W    = 12;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned LOG2_W     = 3;
  localparam int unsigned CTBW_W     = 10;
  localparam int unsigned BLK_W      = 9;
  localparam int unsigned QG_W       = 3;
  localparam int unsigned RS_W       = 19;
  localparam int unsigned REM_W      = CTBW_W;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = 3;

  localparam logic [LOG2_W-1:0] LOG2_CTB_MIN = 3'd4;
  localparam logic [LOG2_W-1:0] LOG2_CTB_MAX = 3'd6;
  localparam logic [LOG2_W-1:0] LOG2_QG_MIN  = 3'd3;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_WR_R2T = 2'd1,
    OP_WR_T2R = 2'd2,
    OP_IGNORE = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG2_CTB  = 2'd0,
    CFG_LOG2_QG   = 2'd1,
    CFG_CTB_WIDTH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [QG_W-1:0] x;
    logic [QG_W-1:0] y;
  } zpos_t;

  typedef struct packed {
    logic               is_query;
    logic               is_first;
    logic               nop;
    logic [COORD_W-1:0] loc_x;
    logic [COORD_W-1:0] loc_y;
    logic [REM_W-1:0]   rem;
    logic [ENTRY_W-1:0] num;
    logic [ENTRY_W-1:0] quo;
  } div_pipe_t;

  function automatic zpos_t prev_zorder(logic [QG_W-1:0] qx, logic [QG_W-1:0] qy);
    logic [2*QG_W-1:0] z;
    zpos_t             p;
    for (int i = 0; i < QG_W; i++) begin
      z[2*i]   = qx[i];
      z[2*i+1] = qy[i];
    end
    z = z - 1'b1;
    for (int i = 0; i < QG_W; i++) begin
      p.x[i] = z[2*i];
      p.y[i] = z[2*i+1];
    end
    return p;
  endfunction

  function automatic div_pipe_t div_steps(div_pipe_t p, logic [CTBW_W-1:0] w);
    div_pipe_t        s;
    logic [REM_W:0]   t;
    logic             q;
    s = p;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {s.rem, s.num[ENTRY_W-1]};
      s.num = {s.num[ENTRY_W-2:0], 1'b0};
      q     = (t >= {1'b0, w});
      if (q) begin
        t = t - {1'b0, w};
      end
      s.rem = t[REM_W-1:0];
      s.quo = {s.quo[ENTRY_W-2:0], q};
    end
    return s;
  endfunction

endpackage

/* hdl/pqga_if.sv */
// Handshake channel interfaces: input words, result words and configuration writes.
interface pqga_item_if;
  logic                            valid;
  logic                            ready;
  logic [pqga_pkg::OP_W-1:0]       op;
  logic [pqga_pkg::COORD_W-1:0]    x_pos;
  logic [pqga_pkg::COORD_W-1:0]    y_pos;
  logic [pqga_pkg::ENTRY_W-1:0]    table_index;
  logic [pqga_pkg::ENTRY_W-1:0]    table_value;

  modport source (output valid, op, x_pos, y_pos, table_index, table_value, input ready);
  modport sink   (input valid, op, x_pos, y_pos, table_index, table_value, output ready);
endinterface

interface pqga_res_if;
  logic                            valid;
  logic                            ready;
  logic [pqga_pkg::COORD_W-1:0]    prev_x;
  logic [pqga_pkg::COORD_W-1:0]    prev_y;
  logic                            no_previous;

  modport source (output valid, prev_x, prev_y, no_previous, input ready);
  modport sink   (input valid, prev_x, prev_y, no_previous, output ready);
endinterface

interface pqga_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pqga_pkg::CFG_IDX_W-1:0]   index;
  logic [pqga_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/prev_quant_group_address.sv */
// Previous quantization group address: top level, seven-stage pipeline.
// An accepted input word is registered in stages A, B and C, the divider stages and the output stage in turn.
// Throughput: one word per cycle while the result channel is ready; the 12-bit divider is pipelined (3 stages).
// Tables are written in pipeline order, so a query sees every earlier write.
// Reset clears valid bits and sets config registers to (6, 3, 1); tables start undefined.
module prev_quant_group_address #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pqga_item_if.sink  item_i,
  pqga_res_if.source result_o,
  pqga_cfg_if.sink   cfg_i
);
  import pqga_pkg::*;

  localparam int unsigned TBL_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  // configuration
  logic [LOG2_W-1:0] log2_ctb_q;
  logic [LOG2_W-1:0] log2_qg_q;
  logic [CTBW_W-1:0] ctb_width_q;
  logic [LOG2_W-1:0] lc;
  logic [LOG2_W-1:0] lq;
  logic [LOG2_W-1:0] dq;
  logic [QG_W-1:0]   qmask;
  logic [CTBW_W-1:0] w;

  // handshake enables
  logic                  en_a;
  logic                  en_b;
  logic                  en_c;
  logic [DIV_STAGES-1:0] en_div;
  logic                  en_out;

  // stage A
  logic                a_v_q;
  logic [OP_W-1:0]     a_op_q;
  logic [BLK_W-1:0]    a_bx_q, a_by_q;
  logic [QG_W-1:0]     a_qx_q, a_qy_q;
  logic [RS_W-1:0]     a_rs_q;
  logic [ENTRY_W-1:0]  a_ti_q, a_tv_q;
  logic [COORD_W-1:0]  bx_full, by_full, qx_full, qy_full;
  logic [BLK_W-1:0]    a_bx_d, a_by_d;
  logic [QG_W-1:0]     a_qx_d, a_qy_d;
  logic [RS_W-1:0]     a_rs_d;

  // stage B
  logic                b_v_q;
  logic [OP_W-1:0]     b_op_q;
  logic                b_first_q, b_rs_zero_q, b_rs_in_q;
  logic [COORD_W-1:0]  b_loc_x_q, b_loc_y_q;
  logic [ENTRY_W-1:0]  b_ti_q, b_tv_q;
  zpos_t               zp;
  logic [COORD_W-1:0]  b_loc_x_d, b_loc_y_d;
  logic                a_ti_in;
  logic                r2t_we;
  logic [ENTRY_W-1:0]  r2t_rdata;

  // stage C
  logic                c_v_q;
  logic                c_query_q, c_first_q, c_nop_q, c_t2r_in_q;
  logic [COORD_W-1:0]  c_loc_x_q, c_loc_y_q;
  logic [ENTRY_W-1:0]  ts;
  logic [ENTRY_W-1:0]  ts_m1;
  logic                c_nop_d;
  logic                c_t2r_in_d;
  logic                b_ti_in;
  logic                t2r_we;
  logic [ENTRY_W-1:0]  t2r_rdata;

  // divider stages
  logic [DIV_STAGES-1:0] div_v_q;
  div_pipe_t             div_pipe [DIV_STAGES+1];

  // output stage
  div_pipe_t           fin;
  logic [COORD_W-1:0]  last;
  logic [COORD_W-1:0]  tbl_x, tbl_y;
  logic                out_v_q;
  logic [COORD_W-1:0]  res_x_q, res_y_q, res_x_d, res_y_d;
  logic                res_nop_q, res_nop_d;

  // configuration port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_ctb_q  <= 3'd6;
      log2_qg_q   <= 3'd3;
      ctb_width_q <= 10'd1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LOG2_CTB:  log2_ctb_q  <= cfg_i.data[LOG2_W-1:0];
        CFG_LOG2_QG:   log2_qg_q   <= cfg_i.data[LOG2_W-1:0];
        CFG_CTB_WIDTH: ctb_width_q <= cfg_i.data[CTBW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lc = (log2_ctb_q < LOG2_CTB_MIN) ? LOG2_CTB_MIN :
         (log2_ctb_q > LOG2_CTB_MAX) ? LOG2_CTB_MAX : log2_ctb_q;
    lq = (log2_qg_q < LOG2_QG_MIN) ? LOG2_QG_MIN :
         (log2_qg_q > lc) ? lc : log2_qg_q;
    dq    = lc - lq;
    qmask = QG_W'((4'd1 << dq) - 4'd1);
    w     = (ctb_width_q == '0) ? CTBW_W'(1) : ctb_width_q;
  end

  // stall chain
  always_comb begin
    en_out = !out_v_q || result_o.ready;
    en_div[DIV_STAGES-1] = !div_v_q[DIV_STAGES-1] || en_out;
    for (int i = DIV_STAGES - 2; i >= 0; i--) begin
      en_div[i] = !div_v_q[i] || en_div[i+1];
    end
    en_c = !c_v_q || en_div[0];
    en_b = !b_v_q || en_c;
    en_a = !a_v_q || en_b;
  end

  assign item_i.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      div_v_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= item_i.valid;
      if (en_b) b_v_q <= a_v_q;
      if (en_c) c_v_q <= b_v_q;
      if (en_div[0]) div_v_q[0] <= c_v_q;
      for (int i = 1; i < DIV_STAGES; i++) begin
        if (en_div[i]) div_v_q[i] <= div_v_q[i-1];
      end
      if (en_out) out_v_q <= div_v_q[DIV_STAGES-1];
    end
  end

  // stage A: block coordinates, group offsets, raster address
  always_comb begin
    bx_full = item_i.x_pos >> lc;
    by_full = item_i.y_pos >> lc;
    qx_full = item_i.x_pos >> lq;
    qy_full = item_i.y_pos >> lq;
    a_bx_d  = bx_full[BLK_W-1:0];
    a_by_d  = by_full[BLK_W-1:0];
    a_qx_d  = qx_full[QG_W-1:0] & qmask;
    a_qy_d  = qy_full[QG_W-1:0] & qmask;
    a_rs_d  = RS_W'(a_by_d) * RS_W'(w) + RS_W'(a_bx_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_op_q <= item_i.op;
      a_bx_q <= a_bx_d;
      a_by_q <= a_by_d;
      a_qx_q <= a_qx_d;
      a_qy_q <= a_qy_d;
      a_rs_q <= a_rs_d;
      a_ti_q <= item_i.table_index;
      a_tv_q <= item_i.table_value;
    end
  end

  // stage B: z-order predecessor, raster-to-tile access
  always_comb begin
    zp        = prev_zorder(a_qx_q, a_qy_q);
    b_loc_x_d = (COORD_W'(a_bx_q) << lc) + (COORD_W'(zp.x) << lq);
    b_loc_y_d = (COORD_W'(a_by_q) << lc) + (COORD_W'(zp.y) << lq);
    a_ti_in   = 32'(a_ti_q) < MAX_BLOCKS;
    r2t_we    = en_b && a_v_q && (a_op_q == OP_WR_R2T) && a_ti_in;
  end

  pqga_tbl #(
    .DEPTH (MAX_BLOCKS),
    .AW    (TBL_AW)
  ) u_r2t (
    .clk_i   (clk_i),
    .we_i    (r2t_we),
    .waddr_i (TBL_AW'(a_ti_q)),
    .wdata_i (a_tv_q),
    .re_i    (en_b),
    .raddr_i (TBL_AW'(a_rs_q)),
    .rdata_o (r2t_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_op_q      <= a_op_q;
      b_first_q   <= (a_qx_q == '0) && (a_qy_q == '0);
      b_rs_zero_q <= (a_rs_q == '0);
      b_rs_in_q   <= 32'(a_rs_q) < MAX_BLOCKS;
      b_loc_x_q   <= b_loc_x_d;
      b_loc_y_q   <= b_loc_y_d;
      b_ti_q      <= a_ti_q;
      b_tv_q      <= a_tv_q;
    end
  end

  // stage C: tile-scan predecessor, tile-to-raster access
  always_comb begin
    ts         = b_rs_in_q ? r2t_rdata : '0;
    ts_m1      = ts - ENTRY_W'(1);
    c_nop_d    = b_first_q && (b_rs_zero_q || (ts == '0));
    c_t2r_in_d = 32'(ts_m1) < MAX_BLOCKS;
    b_ti_in    = 32'(b_ti_q) < MAX_BLOCKS;
    t2r_we     = en_c && b_v_q && (b_op_q == OP_WR_T2R) && b_ti_in;
  end

  pqga_tbl #(
    .DEPTH (MAX_BLOCKS),
    .AW    (TBL_AW)
  ) u_t2r (
    .clk_i   (clk_i),
    .we_i    (t2r_we),
    .waddr_i (TBL_AW'(b_ti_q)),
    .wdata_i (b_tv_q),
    .re_i    (en_c),
    .raddr_i (TBL_AW'(ts_m1)),
    .rdata_o (t2r_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      c_query_q  <= (b_op_q == OP_QUERY);
      c_first_q  <= b_first_q;
      c_nop_q    <= c_nop_d;
      c_t2r_in_q <= c_t2r_in_d;
      c_loc_x_q  <= b_loc_x_q;
      c_loc_y_q  <= b_loc_y_q;
    end
  end

  // divider: previous raster address over picture width
  always_comb begin
    div_pipe[0].is_query = c_query_q;
    div_pipe[0].is_first = c_first_q;
    div_pipe[0].nop      = c_nop_q;
    div_pipe[0].loc_x    = c_loc_x_q;
    div_pipe[0].loc_y    = c_loc_y_q;
    div_pipe[0].rem      = '0;
    div_pipe[0].num      = c_t2r_in_q ? t2r_rdata : '0;
    div_pipe[0].quo      = '0;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    pqga_div_stage u_div (
      .clk_i  (clk_i),
      .en_i   (en_div[g]),
      .w_i    (w),
      .pipe_i (div_pipe[g]),
      .pipe_o (div_pipe[g+1])
    );
  end

  // output stage
  always_comb begin
    fin   = div_pipe[DIV_STAGES];
    last  = (COORD_W'(1) << lc) - (COORD_W'(1) << lq);
    tbl_x = (COORD_W'(fin.rem) << lc) + last;
    tbl_y = (COORD_W'(fin.quo) << lc) + last;
    if (!fin.is_query) begin
      res_x_d   = '0;
      res_y_d   = '0;
      res_nop_d = 1'b0;
    end else if (!fin.is_first) begin
      res_x_d   = fin.loc_x;
      res_y_d   = fin.loc_y;
      res_nop_d = 1'b0;
    end else if (fin.nop) begin
      res_x_d   = '0;
      res_y_d   = '0;
      res_nop_d = 1'b1;
    end else begin
      res_x_d   = tbl_x;
      res_y_d   = tbl_y;
      res_nop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      res_x_q   <= res_x_d;
      res_y_q   <= res_y_d;
      res_nop_q <= res_nop_d;
    end
  end

  assign result_o.valid       = out_v_q;
  assign result_o.prev_x      = res_x_q;
  assign result_o.prev_y      = res_y_q;
  assign result_o.no_previous = res_nop_q;

endmodule

/* hdl/pqga_tbl.sv */
// Single-port-write, registered-read block address table.
module pqga_tbl #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [pqga_pkg::ENTRY_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [pqga_pkg::ENTRY_W-1:0] rdata_o
);
  import pqga_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pqga_div_stage.sv */
// One stage of the raster-address divider: four restoring quotient bits per stage.
module pqga_div_stage (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pqga_pkg::CTBW_W-1:0] w_i,
  input  pqga_pkg::div_pipe_t         pipe_i,
  output pqga_pkg::div_pipe_t         pipe_o
);
  import pqga_pkg::*;

  div_pipe_t pipe_d;
  div_pipe_t pipe_q;

  always_comb begin
    pipe_d = div_steps(pipe_i, w_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign pipe_o = pipe_q;

endmodule
